/* rtl/bsr_pkg.sv */
package bsr_pkg;

  localparam int unsigned MAX_STEPS = 48;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STEP_W    = 7;
  localparam int unsigned SQ_W      = 2 * DATA_W;

  localparam logic [DATA_W-1:0] TOL_RESET = 32'd6554;

  typedef struct packed {
    logic [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] root;
    logic              from_upper;
    logic [STEP_W-1:0] step_count;
    logic              converged;
  } out_t;

  typedef struct packed {
    logic [DATA_W-1:0] tolerance;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // take a new value, open the interval
    logic mult;     // square the selected operand
    logic sel_hi;   // operand is the upper end, else the midpoint
    logic eval;     // test both ends, form the first midpoint
    logic step;     // one halving step
    logic capture;  // latch the result beat
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;
  } status_t;

  // |sq - v2| <= tol2, all three at twice the fraction bits
  function automatic logic within_tol(logic [SQ_W-1:0] sq, logic [SQ_W-1:0] v2,
                                      logic [SQ_W-1:0] tol2);
    logic [SQ_W-1:0] diff;
    diff = (sq >= v2) ? (sq - v2) : (v2 - sq);
    return diff <= tol2;
  endfunction

endpackage

/* rtl/bsr_stream_if.sv */
interface bsr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/bsr_datapath.sv */
module bsr_datapath #(
  parameter int unsigned MaxSteps = bsr_pkg::MAX_STEPS,
  parameter int unsigned FracBits = bsr_pkg::FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bsr_pkg::cmd_t                cmd_i,
  output bsr_pkg::status_t             status_o,
  input  logic [bsr_pkg::DATA_W-1:0]   value_i,
  input  logic                         cfg_we_i,
  input  logic [bsr_pkg::DATA_W-1:0]   cfg_tol_i,
  output bsr_pkg::out_t                result_o
);

  localparam int unsigned DW = bsr_pkg::DATA_W;
  localparam int unsigned SW = bsr_pkg::SQ_W;
  localparam logic [SW-1:0] OneFixed = SW'(1) << FracBits;

  logic [DW-1:0]            tol_q;
  logic [DW-1:0]            value_q;
  logic [DW-1:0]            lo_q, hi_q, mid_q;
  logic [SW-1:0]            prod_q;
  logic                     lo_ok_q, hi_ok_q;
  logic [bsr_pkg::STEP_W-1:0] steps_q;
  bsr_pkg::out_t            result_q;

  logic [SW-1:0] v2, tol2, prod_d;
  logic [DW-1:0] op, hi_init;
  logic [DW:0]   sum_first, sum_lo_side, sum_hi_side;
  logic          mid_below, mid_ok;

  // Work at twice the fraction bits so that no compare rounds
  assign v2   = SW'(value_q) << FracBits;
  assign tol2 = SW'(tol_q) << FracBits;

  assign hi_init = (SW'(value_i) > OneFixed) ? value_i : OneFixed[DW-1:0];

  assign op     = cmd_i.sel_hi ? hi_q : mid_q;
  assign prod_d = SW'(op) * SW'(op);

  assign sum_first   = {1'b0, lo_q}  + {1'b0, hi_q};
  // Both candidate midpoints of the next step, picked by the compare
  assign sum_lo_side = {1'b0, lo_q}  + {1'b0, mid_q};
  assign sum_hi_side = {1'b0, mid_q} + {1'b0, hi_q};

  assign mid_below = prod_q < v2;
  assign mid_ok    = bsr_pkg::within_tol(prod_q, v2, tol2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= bsr_pkg::TOL_RESET;
      lo_q    <= '0;
      hi_q    <= '0;
      steps_q <= '0;
      lo_ok_q <= 1'b0;
      hi_ok_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_tol_i;
      end
      if (cmd_i.load) begin
        lo_q    <= '0;
        hi_q    <= hi_init;
        steps_q <= '0;
        lo_ok_q <= 1'b0;
        hi_ok_q <= 1'b0;
      end else if (cmd_i.eval) begin
        lo_ok_q <= bsr_pkg::within_tol('0, v2, tol2);
        hi_ok_q <= mid_ok;
      end else if (cmd_i.step) begin
        steps_q <= steps_q + 1'b1;
        if (mid_below) begin
          lo_q    <= mid_q;
          lo_ok_q <= mid_ok;
        end else begin
          hi_q    <= mid_q;
          hi_ok_q <= mid_ok;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_i;
    end
    if (cmd_i.mult) begin
      prod_q <= prod_d;
    end
    if (cmd_i.eval) begin
      mid_q <= sum_first[DW:1];
    end else if (cmd_i.step) begin
      mid_q <= mid_below ? sum_hi_side[DW:1] : sum_lo_side[DW:1];
    end
    if (cmd_i.capture) begin
      result_q.root       <= (lo_ok_q || !hi_ok_q) ? lo_q : hi_q;
      result_q.from_upper <= !lo_ok_q && hi_ok_q;
      result_q.step_count <= steps_q;
      result_q.converged  <= lo_ok_q || hi_ok_q;
    end
  end

  assign status_o.done = lo_ok_q || hi_ok_q ||
                         (steps_q >= bsr_pkg::STEP_W'(MaxSteps));
  assign result_o = result_q;

  a_steps_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= bsr_pkg::STEP_W'(MaxSteps))
    else $error("step counter ran past the cap");

  a_interval_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= hi_q)
    else $error("lower end above upper end");

endmodule

/* rtl/bsr_ctrl.sv */
module bsr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  bsr_pkg::status_t  status_i,
  output bsr_pkg::cmd_t     cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SQ_HI  = 5'b00010,
    S_EVAL   = 5'b00100,
    S_MULT   = 5'b01000,
    S_UPDATE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SQ_HI;
        end
      end
      S_SQ_HI: begin
        cmd_o.mult   = 1'b1;
        cmd_o.sel_hi = 1'b1;
        state_d      = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_MULT;
      end
      S_MULT: begin
        cmd_o.mult = 1'b1;
        if (!status_i.done) begin
          state_d = S_UPDATE;
        end else if (!out_valid_q || out_ready_i) begin
          // hold here while the previous beat is still unclaimed
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_UPDATE: begin
        cmd_o.step = 1'b1;
        state_d    = S_MULT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_capture_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> status_i.done && (!out_valid_q || out_ready_i))
    else $error("result latched before the search finished or over a waiting beat");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_SQ_HI))
    else $error("accepted beat did not start a search");

endmodule

/* rtl/bisection_square_root_unit.sv */
// Channel  Role    Payload                                      Beat taken when
// in_i     sink    value (32b, unsigned Q16.16)                 valid && ready
// out_o    source  root, from_upper, step_count, converged      valid && ready
// cfg_i    sink    tolerance (32b, unsigned Q16.16)             valid && ready
//
// Occupancy: an item holds the unit from its acceptance to the earliest next
//   acceptance, taking n halving steps (at most MaxSteps); no new value is
//   taken before its search is done. Each step is one pass through the
//   single 32x32 squarer plus a compare-and-update.
// Reset: rst_ni clears the controller, the interval and the tolerance
//   (back to 0.1); no clearing pass is needed.
// Stalls: a new value is taken as soon as the unit is idle, even while the
//   last result waits on out_o; a search that finishes then holds until that
//   beat is taken. cfg_i is always ready.
module bisection_square_root_unit #(
  parameter int unsigned MaxSteps = bsr_pkg::MAX_STEPS,
  parameter int unsigned FracBits = bsr_pkg::FRAC_BITS
) (
  input logic   clk_i,
  input logic   rst_ni,
  bsr_stream_if.sink   in_i,
  bsr_stream_if.source out_o,
  bsr_stream_if.sink   cfg_i
);

  bsr_pkg::cmd_t    cmd;
  bsr_pkg::status_t status;
  bsr_pkg::out_t    result;

  // Tolerance writes land directly in the datapath register
  assign cfg_i.ready = 1'b1;

  bsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Squarer, interval ends, tolerance flags and the result register
  bsr_datapath #(
    .MaxSteps (MaxSteps),
    .FracBits (FracBits)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .value_i   (in_i.payload.value),
    .cfg_we_i  (cfg_i.valid),
    .cfg_tol_i (cfg_i.payload.tolerance),
    .result_o  (result)
  );

  assign out_o.payload = result;

endmodule

/* verif/bisection_square_root_unit_tb.sv */
module bisection_square_root_unit_tb;

  // Worst search: every step taken, plus load and hand-off
  localparam int unsigned SEARCH_CYCLES = 2 * bsr_pkg::MAX_STEPS + 4;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned PHASE_ITEMS   = 175;
  localparam int unsigned PHASE_COUNT   = 8;
  localparam logic [bsr_pkg::DATA_W-1:0] ONE_Q16 = 32'd1 << bsr_pkg::FRAC_BITS;

  logic clk_i = 1'b0;
  logic rst_ni;

  bsr_stream_if #(.payload_t(bsr_pkg::in_t))  value_if ();
  bsr_stream_if #(.payload_t(bsr_pkg::out_t)) root_if ();
  bsr_stream_if #(.payload_t(bsr_pkg::cfg_t)) tol_if ();

  bisection_square_root_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (value_if),
    .out_o  (root_if),
    .cfg_i  (tol_if)
  );

  // Mirror of the tolerance register, updated on each accepted cfg beat
  logic [bsr_pkg::DATA_W-1:0] tol_mirror;
  bsr_pkg::out_t              root_expect_q[$];
  int unsigned                fail_count;
  int unsigned                cycle_count;
  int unsigned                send_idle_pct;
  int unsigned                recv_stall_pct;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Hard stop for a hung handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // |e*e - v2| with both sides at twice the fraction bits
  function automatic logic [bsr_pkg::SQ_W-1:0] square_miss(
      input logic [bsr_pkg::DATA_W-1:0] e,
      input logic [bsr_pkg::SQ_W-1:0]   v2);
    logic [bsr_pkg::SQ_W-1:0] sq;
    sq = {32'd0, e} * {32'd0, e};
    return (sq >= v2) ? (sq - v2) : (v2 - sq);
  endfunction

  // Run the whole halving search for one value and form the result beat
  function automatic bsr_pkg::out_t predict_root(input logic [bsr_pkg::DATA_W-1:0] value,
                                                 input logic [bsr_pkg::DATA_W-1:0] tol);
    logic [bsr_pkg::SQ_W-1:0]   v2;
    logic [bsr_pkg::SQ_W-1:0]   tol2;
    logic [bsr_pkg::SQ_W-1:0]   mid_sq;
    logic [bsr_pkg::DATA_W-1:0] lo;
    logic [bsr_pkg::DATA_W-1:0] hi;
    logic [bsr_pkg::DATA_W-1:0] mid;
    logic [bsr_pkg::STEP_W-1:0] steps;
    logic                       lo_ok;
    logic                       hi_ok;
    bsr_pkg::out_t              res;
    v2    = {32'd0, value} << bsr_pkg::FRAC_BITS;
    tol2  = {32'd0, tol} << bsr_pkg::FRAC_BITS;
    lo    = '0;
    hi    = (value > ONE_Q16) ? value : ONE_Q16;
    steps = '0;
    lo_ok = square_miss(lo, v2) <= tol2;
    hi_ok = square_miss(hi, v2) <= tol2;
    while (!lo_ok && !hi_ok && steps < bsr_pkg::MAX_STEPS) begin
      steps  = steps + 1'b1;
      mid    = bsr_pkg::DATA_W'(({32'd0, lo} + {32'd0, hi}) >> 1);
      mid_sq = {32'd0, mid} * {32'd0, mid};
      if (mid_sq < v2) begin
        lo = mid;
      end else begin
        hi = mid;
      end
      lo_ok = square_miss(lo, v2) <= tol2;
      hi_ok = square_miss(hi, v2) <= tol2;
    end
    // Lower end wins a tie; the step cap reports the lower end too
    res.root       = (!lo_ok && hi_ok) ? hi : lo;
    res.from_upper = !lo_ok && hi_ok;
    res.step_count = steps;
    res.converged  = lo_ok || hi_ok;
    return res;
  endfunction

  // Values biased towards exact and near squares, small numbers and the full range
  function automatic logic [bsr_pkg::DATA_W-1:0] pick_value();
    logic [bsr_pkg::DATA_W-1:0] r;
    r = {16'd0, 16'($urandom)};
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($urandom_range(32'h3FFFF));
      2: return r * r;
      3: return r * r + 32'($urandom_range(6)) - 32'd3;
      default: return {16'($urandom_range(255)), 16'd0};
    endcase
  endfunction

  function automatic logic [bsr_pkg::DATA_W-1:0] pick_tolerance();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return 32'($urandom_range(32'hFFFF));
      3: return $urandom;
      default: return bsr_pkg::TOL_RESET;
    endcase
  endfunction

  // Offer one value beat, idling first at random, and book its result on acceptance
  task automatic send_value(input logic [bsr_pkg::DATA_W-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      value_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    value_if.valid         <= 1'b1;
    value_if.payload.value <= value;
    @(posedge clk_i);
    while (!value_if.ready) @(posedge clk_i);
    root_expect_q.push_back(predict_root(value, tol_mirror));
  endtask

  // Drop the value channel and hold until every booked result has arrived
  task automatic drain_results();
    value_if.valid <= 1'b0;
    while (root_expect_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write the tolerance while the unit is idle
  task automatic write_tolerance(input logic [bsr_pkg::DATA_W-1:0] tol);
    drain_results();
    tol_if.valid             <= 1'b1;
    tol_if.payload.tolerance <= tol;
    @(posedge clk_i);
    while (!tol_if.ready) @(posedge clk_i);
    tol_mirror = tol;
    tol_if.valid <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Result checker: compare each accepted beat with the oldest booked result,
  // then decide the ready for the next cycle
  always @(posedge clk_i) begin
    bsr_pkg::out_t want;
    if (root_if.valid && root_if.ready) begin
      if (root_expect_q.size() == 0) begin
        $error("unexpected result beat: root %0h", root_if.payload.root);
        fail_count++;
      end else begin
        want = root_expect_q.pop_front();
        if (root_if.payload.root !== want.root) begin
          $error("root: expected %0h, actual %0h", want.root, root_if.payload.root);
          fail_count++;
        end
        if (root_if.payload.from_upper !== want.from_upper) begin
          $error("from_upper: expected %0d, actual %0d", want.from_upper,
                 root_if.payload.from_upper);
          fail_count++;
        end
        if (root_if.payload.step_count !== want.step_count) begin
          $error("step_count: expected %0d, actual %0d", want.step_count,
                 root_if.payload.step_count);
          fail_count++;
        end
        if (root_if.payload.converged !== want.converged) begin
          $error("converged: expected %0d, actual %0d", want.converged,
                 root_if.payload.converged);
          fail_count++;
        end
      end
    end
    root_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Reset tolerance: field extremes, integer and fractional squares, non-squares
  task automatic test_reset_tolerance();
    set_idling(0, 0);
    send_value(32'h0000_0000);
    send_value(32'h0000_0001);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'h0000_FFFF);
    send_value(ONE_Q16);
    send_value(32'h0000_8000);
    send_value(32'h0001_0001);
    send_value(32'h0002_0000);
    send_value(32'h0004_0000);
    send_value(32'h0001_9000);
    send_value(32'h0009_0000);
  endtask

  // Zero tolerance: exact squares converge, the rest run to the step cap,
  // including a tiny value whose interval sticks one unit wide
  task automatic test_zero_tolerance();
    write_tolerance('0);
    send_value(32'h0004_0000);
    send_value(32'h0001_9000);
    send_value(32'h0000_0000);
    send_value(32'h0002_0000);
    send_value(32'h0000_0003);
  endtask

  // Widest tolerance: the lower end passes at once, and where both ends pass the lower end must win
  task automatic test_wide_tolerance();
    write_tolerance('1);
    send_value(32'h0000_8000);
    send_value(32'hFFFF_FFFF);
    send_value(ONE_Q16);
  endtask

  // Random values over several tolerances and every idling pattern; each
  // tolerance change also pauses the sender until the unit has emptied
  task automatic test_random_phases();
    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      write_tolerance((phase == 0) ? bsr_pkg::TOL_RESET : pick_tolerance());
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(66, 0);
        2: set_idling(0, 66);
        default: set_idling(9, 9);
      endcase
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        send_value(pick_value());
      end
    end
  endtask

  initial begin
    rst_ni                   = 1'b0;
    value_if.valid           = 1'b0;
    value_if.payload         = '0;
    tol_if.valid             = 1'b0;
    tol_if.payload           = '0;
    root_if.ready            = 1'b0;
    tol_mirror               = bsr_pkg::TOL_RESET;
    fail_count               = 0;
    cycle_count              = 0;
    send_idle_pct            = 0;
    recv_stall_pct           = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_tolerance();
    test_zero_tolerance();
    test_wide_tolerance();
    test_random_phases();

    // Empty the unit, then allow one more full search for any stray beat
    drain_results();
    repeat (SEARCH_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && root_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
